// File: rtl/core/mq_pkg.sv
// Package for the middle insert queue: sizes, command and status codes,
// ring pointer arithmetic and the memory port bundle.
// No dependencies.
package mq_pkg;

    // Total number of entries the queue can hold.
    localparam int CAPACITY   = 1024;
    // Each half holds at most this many entries.
    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int PTR_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int TOT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Fixed field widths.
    localparam int ID_W     = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 11;

    // Command codes.
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_MID  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    // One memory port set: a write port and a read address.
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic [PTR_W-1:0] raddr;
    } t_ram_port;

    // Ring position a + b, modulo the half depth; b never exceeds the depth,
    // so one compare and subtract is enough.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {{(SUM_W-PTR_W){1'b0}}, a} + {1'b0, b};
        if (s >= SUM_W'(HALF_DEPTH)) begin
            s = s - SUM_W'(HALF_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

// File: rtl/core/mq_ram.sv
// Generic single write, single read synchronous memory with registered read
// data. No dependencies.
module mq_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/mq_ctrl.sv
// Control for the middle insert queue: ring pointers, counts, command
// sequencing and result registers. Depends on mq_pkg.
module mq_ctrl import mq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ID_W-1:0]     i_item_id,
    input  logic [ID_W-1:0]     i_front_rdata,
    input  logic [ID_W-1:0]     i_back_rdata,
    output t_ram_port           o_front_port,
    output t_ram_port           o_back_port,
    output logic                o_valid,
    output logic [ID_W-1:0]     o_popped_id,
    output logic [STATUS_W-1:0] o_status,
    output logic [SIZE_W-1:0]   o_queue_size
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state            r_state;
    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_item_id;
    logic [PTR_W-1:0]  r_front_head, n_front_head;
    logic [CNT_W-1:0]  r_front_count, n_front_count;
    logic [PTR_W-1:0]  r_back_head, n_back_head;
    logic [CNT_W-1:0]  r_back_count, n_back_count;

    logic [TOT_W-1:0]    total;
    logic [TOT_W-1:0]    n_total;
    logic                even;
    logic [PTR_W-1:0]    front_tail;
    logic [PTR_W-1:0]    back_tail;
    logic [ID_W-1:0]     n_popped_id;
    logic [STATUS_W-1:0] n_status;

    assign busy = (r_state == S_EXEC);

    // Current size and tail positions of both halves.
    always_comb begin
        total      = TOT_W'(r_front_count) + TOT_W'(r_back_count);
        even       = ~total[0];
        front_tail = ring_add(r_front_head, r_front_count);
        back_tail  = ring_add(r_back_head, r_back_count);
    end

    // Execute one command: memory writes and next pointer values. The heads
    // are read every cycle; the data registered at the accept edge is what
    // the execute cycle works on.
    always_comb begin
        o_front_port.raddr  = r_front_head;
        o_back_port.raddr   = r_back_head;
        n_front_head        = r_front_head;
        n_front_count       = r_front_count;
        n_back_head         = r_back_head;
        n_back_count        = r_back_count;
        n_total             = total;
        n_popped_id         = '0;
        n_status            = STATUS_DONE;
        o_front_port.we     = 1'b0;
        o_front_port.waddr  = front_tail;
        o_front_port.wdata  = r_item_id;
        o_back_port.we      = 1'b0;
        o_back_port.waddr   = back_tail;
        o_back_port.wdata   = r_item_id;
        if (r_state == S_EXEC) begin
            unique case (r_kind)
                KIND_PUSH_BACK: begin
                    if (total >= TOT_W'(CAPACITY)) begin
                        n_status = STATUS_PUSH_FULL;
                    end else begin
                        n_total = total + 1'b1;
                        if (!even) begin
                            o_back_port.we = 1'b1;
                            n_back_count   = r_back_count + 1'b1;
                        end else if (r_back_count == '0) begin
                            // The new item passes straight to the front half.
                            o_front_port.we = 1'b1;
                            n_front_count   = r_front_count + 1'b1;
                        end else begin
                            // Back head moves to the front tail, item to back tail.
                            o_front_port.we    = 1'b1;
                            o_front_port.wdata = i_back_rdata;
                            o_back_port.we     = 1'b1;
                            n_back_head        = ring_add(r_back_head, CNT_W'(1));
                            n_front_count      = r_front_count + 1'b1;
                        end
                    end
                end
                KIND_PUSH_MID: begin
                    if (total >= TOT_W'(CAPACITY)) begin
                        n_status = STATUS_PUSH_FULL;
                    end else begin
                        n_total = total + 1'b1;
                        if (even) begin
                            o_front_port.we = 1'b1;
                            n_front_count   = r_front_count + 1'b1;
                        end else begin
                            n_back_head       = ring_add(r_back_head,
                                                         CNT_W'(HALF_DEPTH - 1));
                            o_back_port.we    = 1'b1;
                            o_back_port.waddr = n_back_head;
                            n_back_count      = r_back_count + 1'b1;
                        end
                    end
                end
                KIND_POP: begin
                    if (r_front_count == '0) begin
                        n_status = STATUS_POP_EMPTY;
                    end else begin
                        n_total      = total - 1'b1;
                        n_popped_id  = i_front_rdata;
                        n_front_head = ring_add(r_front_head, CNT_W'(1));
                        if (even) begin
                            // Refill: back head goes to the freed front tail.
                            o_front_port.we    = 1'b1;
                            o_front_port.wdata = i_back_rdata;
                            n_back_head        = ring_add(r_back_head, CNT_W'(1));
                            n_back_count       = r_back_count - 1'b1;
                        end else begin
                            n_front_count = r_front_count - 1'b1;
                        end
                    end
                end
                KIND_UNUSED: begin
                    n_status = STATUS_DONE;
                end
                default: begin
                    n_status = STATUS_DONE;
                end
            endcase
        end
    end

    // Sequencer, pointer state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_front_head  <= '0;
            r_front_count <= '0;
            r_back_head   <= '0;
            r_back_count  <= '0;
            o_valid       <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind    <= i_kind;
                        r_item_id <= i_item_id;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_front_head  <= n_front_head;
                    r_front_count <= n_front_count;
                    r_back_head   <= n_back_head;
                    r_back_count  <= n_back_count;
                    o_valid       <= 1'b1;
                    o_popped_id   <= n_popped_id;
                    o_status      <= n_status;
                    o_queue_size  <= SIZE_W'(n_total);
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/middle_insert_queue.sv
// Top level of the middle insert queue: two half memories and the control.
// Depends on mq_pkg, mq_ram and mq_ctrl.
//
//   Channel  | Handshake      | Signals
//   ---------+----------------+--------------------------------------------
//   command  | start / busy   | i_kind, i_item_id
//   result   | o_valid strobe | o_popped_id, o_status, o_queue_size
//
// For each item, the accept edge reads both half heads from the
// memories, the next edge writes back and updates the ring pointers.
// The result strobe shows in the cycle after that, in which busy is already
// low and the next item may be accepted, so no new item is taken while one is at work.
// Reset clears the pointers and counts; memory contents are not cleared.
// The receiver cannot stall the result.
module middle_insert_queue import mq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [ID_W-1:0]     i_item_id,
    output logic                o_valid,
    output logic [ID_W-1:0]     o_popped_id,
    output logic [STATUS_W-1:0] o_status,
    output logic [SIZE_W-1:0]   o_queue_size
);

    t_ram_port       front_port;
    t_ram_port       back_port;
    logic [ID_W-1:0] front_rdata;
    logic [ID_W-1:0] back_rdata;

    // Front half: the first ceil(n/2) entries.
    mq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (ID_W),
        .ADDR_W (PTR_W)
    ) u_front_ram (
        .i_clk   (i_clk),
        .i_we    (front_port.we),
        .i_waddr (front_port.waddr),
        .i_wdata (front_port.wdata),
        .i_raddr (front_port.raddr),
        .o_rdata (front_rdata)
    );

    // Back half: the remaining floor(n/2) entries.
    mq_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (ID_W),
        .ADDR_W (PTR_W)
    ) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (back_port.we),
        .i_waddr (back_port.waddr),
        .i_wdata (back_port.wdata),
        .i_raddr (back_port.raddr),
        .o_rdata (back_rdata)
    );

    // Command sequencing and pointer state.
    mq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_item_id     (i_item_id),
        .i_front_rdata (front_rdata),
        .i_back_rdata  (back_rdata),
        .o_front_port  (front_port),
        .o_back_port   (back_port),
        .o_valid       (o_valid),
        .o_popped_id   (o_popped_id),
        .o_status      (o_status),
        .o_queue_size  (o_queue_size)
    );

endmodule

// File: rtl/core/mq_checker.sv
// Port level checks for the middle insert queue, bound to the top level.
// Depends on mq_pkg and middle_insert_queue.
module mq_checker import mq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic [ID_W-1:0]     o_popped_id,
    input logic [STATUS_W-1:0] o_status,
    input logic [SIZE_W-1:0]   o_queue_size
);

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Every accepted item gives its result strobe once its execute state is through.
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing after accepted item");

    // A result never comes while an item is still at work.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A refused item carries no popped identifier.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STATUS_DONE) |-> (o_popped_id == '0))
        else $error("refused item with nonzero popped identifier");

    // A pop is refused only on an empty queue.
    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_POP_EMPTY) |-> (o_queue_size == '0))
        else $error("pop refused while queue not empty");

endmodule

bind middle_insert_queue mq_checker u_mq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_popped_id  (o_popped_id),
    .o_status     (o_status),
    .o_queue_size (o_queue_size)
);
